// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ON(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check that a property never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/rrc_si_pkg.sv
// Shared types, constants and the RRC tap table for the symbol interpolator.
package rrc_si_pkg;

  localparam int unsigned DEF_TAP_COUNT = 81;
  localparam int unsigned DEF_UPSAMPLE  = 10;

  localparam int unsigned SYM_W      = 3;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned TAP_W      = 16;
  localparam int unsigned TERM_W     = 19;
  localparam int unsigned GAIN_W     = 20;
  localparam int unsigned FRAC_SHIFT = 23;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned TAP_IDX_W  = 8;
  localparam int unsigned ROM_LEN    = 81;
  localparam int unsigned ROM_MID    = 40;
  localparam int unsigned HALF_IDX_W = 6;

  // sqrt(10) * 448 in units of 2^-8
  localparam logic signed [GAIN_W-1:0] GAIN = 20'sd362673;
  localparam logic [SAMPLE_W-1:0] MID_RESET = 12'd2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INVERT_PHASE = 2'd0,
    CFG_MID_LEVEL    = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_SCALE,
    S_ROUND
  } state_e;

  typedef struct packed {
    logic                    hist_load;
    logic                    mac_step;
    logic                    acc_clr;
    logic                    acc_add;
    logic                    scale;
    logic                    out_load;
    logic                    out_last;
    logic signed [TAP_W-1:0] tap;
  } ctrl_t;

  // First half of the symmetric Q1.15 RRC response, through the center tap
  localparam logic signed [TAP_W-1:0] RRC_HALF [ROM_MID+1] = '{
    -16'sd105, -16'sd96, -16'sd64, -16'sd12, 16'sd51, 16'sd111, 16'sd156, 16'sd174,
    16'sd158, 16'sd108, 16'sd31, -16'sd57, -16'sd139, -16'sd193, -16'sd202, -16'sd155,
    -16'sd56, 16'sd83, 16'sd236, 16'sd368, 16'sd440, 16'sd417, 16'sd277, 16'sd14,
    -16'sd352, -16'sd777, -16'sd1196, -16'sd1524, -16'sd1670, -16'sd1551, -16'sd1100,
    -16'sd279, 16'sd908, 16'sd2414, 16'sd4151, 16'sd5996, 16'sd7801, 16'sd9412,
    16'sd10684, 16'sd11498, 16'sd11779
  };

  // Tap lookup; indices past the table read as zero
  function automatic logic signed [TAP_W-1:0] rrc_tap(input logic [TAP_IDX_W-1:0] idx);
    logic [TAP_IDX_W-1:0]  mir;
    logic [HALF_IDX_W-1:0] h;
    mir = (idx > TAP_IDX_W'(ROM_MID)) ? TAP_IDX_W'(ROM_LEN - 1) - idx : idx;
    h   = mir[HALF_IDX_W-1:0];
    if (idx >= TAP_IDX_W'(ROM_LEN)) begin
      return '0;
    end
    return RRC_HALF[h];
  endfunction

endpackage

// File: hw/rtl/rrc_si_ctrl.sv
// Sequencer: walks samples and history terms, drives the shared multiplier.
module rrc_si_ctrl #(
  parameter int unsigned TAP_COUNT = rrc_si_pkg::DEF_TAP_COUNT,
  parameter int unsigned UPSAMPLE  = rrc_si_pkg::DEF_UPSAMPLE
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                out_free_i,
  output rrc_si_pkg::ctrl_t   ctrl_o
);

  localparam int unsigned HIST_LEN = (TAP_COUNT - 1) / UPSAMPLE + 1;
  localparam int unsigned M_W      = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
  localparam int unsigned J_W      = $clog2(UPSAMPLE);
  localparam int unsigned IDX_W    = $clog2(TAP_COUNT) + 2;

  rrc_si_pkg::state_e state_q, state_d;
  logic [M_W-1:0]          m_q, m_d;
  logic [J_W-1:0]          j_q, j_d;
  logic signed [IDX_W-1:0] idx_q, idx_d;
  logic                    in_fire;
  logic                    term_last;
  logic                    sample_last;

  assign in_fire     = (state_q == rrc_si_pkg::S_IDLE) && in_valid_i;
  assign term_last   = (m_q == M_W'(HIST_LEN - 1));
  assign sample_last = (j_q == J_W'(UPSAMPLE - 1));
  assign in_stall_o  = (state_q != rrc_si_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrc_si_pkg::S_IDLE: begin
        if (in_valid_i) state_d = rrc_si_pkg::S_MAC;
      end
      rrc_si_pkg::S_MAC: begin
        if (term_last) state_d = rrc_si_pkg::S_DRAIN;
      end
      rrc_si_pkg::S_DRAIN: state_d = rrc_si_pkg::S_SCALE;
      rrc_si_pkg::S_SCALE: state_d = rrc_si_pkg::S_ROUND;
      rrc_si_pkg::S_ROUND: begin
        if (out_free_i) begin
          state_d = sample_last ? rrc_si_pkg::S_IDLE : rrc_si_pkg::S_MAC;
        end
      end
      default: state_d = rrc_si_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.hist_load = in_fire;
    ctrl_o.out_last  = sample_last;
    if (idx_q[IDX_W-1]) begin
      ctrl_o.tap = '0;
    end else begin
      ctrl_o.tap = rrc_si_pkg::rrc_tap(rrc_si_pkg::TAP_IDX_W'(idx_q));
    end
    unique case (state_q)
      rrc_si_pkg::S_IDLE:  ctrl_o.acc_clr = 1'b1;
      rrc_si_pkg::S_MAC: begin
        ctrl_o.mac_step = 1'b1;
        ctrl_o.acc_add  = (m_q != '0);
      end
      rrc_si_pkg::S_DRAIN: ctrl_o.acc_add = 1'b1;
      rrc_si_pkg::S_SCALE: ctrl_o.scale = 1'b1;
      rrc_si_pkg::S_ROUND: begin
        ctrl_o.acc_clr  = 1'b1;
        ctrl_o.out_load = out_free_i;
      end
      default: ctrl_o.acc_clr = 1'b1;
    endcase
  end

  always_comb begin
    m_d   = m_q;
    j_d   = j_q;
    idx_d = idx_q;
    if (in_fire) begin
      m_d   = '0;
      j_d   = '0;
      idx_d = IDX_W'(TAP_COUNT - 1);
    end else if (state_q == rrc_si_pkg::S_MAC) begin
      m_d   = m_q + M_W'(1);
      idx_d = idx_q - IDX_W'(UPSAMPLE);
    end else if ((state_q == rrc_si_pkg::S_ROUND) && out_free_i && !sample_last) begin
      // advance to the next sample of this symbol
      m_d   = '0;
      j_d   = j_q + J_W'(1);
      idx_d = IDX_W'(TAP_COUNT - 2) - IDX_W'(j_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrc_si_pkg::S_IDLE;
      m_q     <= '0;
      j_q     <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      m_q     <= m_d;
      j_q     <= j_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// File: hw/rtl/rrc_si_mac.sv
// Datapath: symbol history, shared multiplier, accumulator and output saturation.
module rrc_si_mac #(
  parameter int unsigned TAP_COUNT = rrc_si_pkg::DEF_TAP_COUNT,
  parameter int unsigned UPSAMPLE  = rrc_si_pkg::DEF_UPSAMPLE
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  rrc_si_pkg::ctrl_t                        ctrl_i,
  input  logic                                     invert_phase_i,
  input  logic [rrc_si_pkg::SAMPLE_W-1:0]          mid_level_i,
  input  logic signed [rrc_si_pkg::SYM_W-1:0]      symbol_i,
  output logic [rrc_si_pkg::SAMPLE_W-1:0]          sample_o
);

  localparam int unsigned SYM_W    = rrc_si_pkg::SYM_W;
  localparam int unsigned SAMPLE_W = rrc_si_pkg::SAMPLE_W;
  localparam int unsigned GAIN_W   = rrc_si_pkg::GAIN_W;
  localparam int unsigned FRAC     = rrc_si_pkg::FRAC_SHIFT;
  localparam int unsigned HIST_LEN = (TAP_COUNT - 1) / UPSAMPLE + 1;
  localparam int unsigned ACC_W    = rrc_si_pkg::TERM_W + $clog2(HIST_LEN + 1);
  localparam int unsigned P_W      = ACC_W + GAIN_W;
  localparam int unsigned T_W      = P_W + 1;

  logic signed [SYM_W-1:0]  hist_q [HIST_LEN];
  logic signed [SYM_W-1:0]  sym_entry;
  logic signed [ACC_W-1:0]  mul_a;
  logic signed [GAIN_W-1:0] mul_b;
  logic signed [P_W-1:0]    prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [T_W-1:0]    total;

  // Negate unless inverted; the most negative code saturates to +3
  always_comb begin
    if (invert_phase_i) begin
      sym_entry = symbol_i;
    end else if (symbol_i == 3'sb100) begin
      sym_entry = 3'sd3;
    end else begin
      sym_entry = -symbol_i;
    end
  end

  // Shift a new symbol in; rotate once per term so entry 0 walks the history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HIST_LEN; k++) hist_q[k] <= '0;
    end else if (ctrl_i.hist_load) begin
      hist_q[0] <= sym_entry;
      for (int k = 1; k < HIST_LEN; k++) hist_q[k] <= hist_q[k-1];
    end else if (ctrl_i.mac_step) begin
      for (int k = 0; k < HIST_LEN - 1; k++) hist_q[k] <= hist_q[k+1];
      hist_q[HIST_LEN-1] <= hist_q[0];
    end
  end

  always_comb begin
    if (ctrl_i.mac_step) begin
      mul_a = {{(ACC_W - SYM_W){hist_q[0][SYM_W-1]}}, hist_q[0]};
      mul_b = {{(GAIN_W - rrc_si_pkg::TAP_W){ctrl_i.tap[rrc_si_pkg::TAP_W-1]}}, ctrl_i.tap};
    end else begin
      mul_a = acc_q;
      mul_b = rrc_si_pkg::GAIN;
    end
    prod_d = prod_q;
    if (ctrl_i.mac_step || ctrl_i.scale) prod_d = mul_a * mul_b;

    acc_d = acc_q;
    if (ctrl_i.acc_clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc_add) begin
      acc_d = acc_q + prod_q[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // Offset, truncate and saturate to the DAC range
  always_comb begin
    total = $signed({prod_q[P_W-1], prod_q})
          + $signed({{(T_W - SAMPLE_W - FRAC){1'b0}}, mid_level_i, {FRAC{1'b0}}});
    if (total[T_W-1]) begin
      sample_o = '0;
    end else if (|total[T_W-2:FRAC+SAMPLE_W]) begin
      sample_o = '1;
    end else begin
      sample_o = total[FRAC+SAMPLE_W-1:FRAC];
    end
  end

endmodule

// File: hw/rtl/rrc_symbol_interpolator.sv
// Top level of the RRC symbol interpolator: config registers and output register.
//
//   channel  | direction | handshake                  | payload
//   symbol   | in        | symbol_valid_i / _stall_o  | symbol_i
//   sample   | out       | sample_valid_o / _stall_i  | sample_o, last_of_symbol_o
//   cfg      | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// For each sample of a symbol, one multiplier serves every history term and then the output gain.
// Reset clears the symbol history and sets invert_phase to 0, mid_level to 2048.
// A stalled sample waits in the output register while the next sample is computed;
// the sequencer holds only when that next sample is ready and the register is full and still stalled.
module rrc_symbol_interpolator #(
  parameter int unsigned TAP_COUNT = rrc_si_pkg::DEF_TAP_COUNT,
  parameter int unsigned UPSAMPLE  = rrc_si_pkg::DEF_UPSAMPLE
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    symbol_valid_i,
  output logic                                    symbol_stall_o,
  input  logic signed [rrc_si_pkg::SYM_W-1:0]     symbol_i,
  output logic                                    sample_valid_o,
  input  logic                                    sample_stall_i,
  output logic [rrc_si_pkg::SAMPLE_W-1:0]         sample_o,
  output logic                                    last_of_symbol_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [rrc_si_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rrc_si_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  rrc_si_pkg::ctrl_t                ctrl;
  logic                             out_free;
  logic                             invert_q, invert_d;
  logic [rrc_si_pkg::SAMPLE_W-1:0]  mid_q, mid_d;
  logic [rrc_si_pkg::SAMPLE_W-1:0]  sample_w;
  logic                             out_valid_q, out_valid_d;
  logic [rrc_si_pkg::SAMPLE_W-1:0]  sample_q;
  logic                             last_q;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !sample_stall_i;

  rrc_si_ctrl #(
    .TAP_COUNT (TAP_COUNT),
    .UPSAMPLE  (UPSAMPLE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (symbol_valid_i),
    .in_stall_o (symbol_stall_o),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  rrc_si_mac #(
    .TAP_COUNT (TAP_COUNT),
    .UPSAMPLE  (UPSAMPLE)
  ) u_mac (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .invert_phase_i (invert_q),
    .mid_level_i    (mid_q),
    .symbol_i       (symbol_i),
    .sample_o       (sample_w)
  );

  always_comb begin
    invert_d = invert_q;
    mid_d    = mid_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (rrc_si_pkg::cfg_reg_e'(cfg_index_i))
        rrc_si_pkg::CFG_INVERT_PHASE: invert_d = cfg_data_i[0];
        rrc_si_pkg::CFG_MID_LEVEL:    mid_d    = cfg_data_i[rrc_si_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !sample_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q    <= 1'b0;
      mid_q       <= rrc_si_pkg::MID_RESET;
      out_valid_q <= 1'b0;
    end else begin
      invert_q    <= invert_d;
      mid_q       <= mid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      sample_q <= sample_w;
      last_q   <= ctrl.out_last;
    end
  end

  assign sample_valid_o   = out_valid_q;
  assign sample_o         = sample_q;
  assign last_of_symbol_o = last_q;

endmodule

// File: hw/rtl/rrc_si_checker.sv
// Port-level checker for the RRC symbol interpolator, bound to the top level.
`include "assert_macros.svh"

module rrc_si_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                symbol_valid_i,
  input logic                                symbol_stall_o,
  input logic                                sample_valid_o,
  input logic                                sample_stall_i,
  input logic [rrc_si_pkg::SAMPLE_W-1:0]     sample_o,
  input logic                                last_of_symbol_o
);

  logic                              in_xfer;
  logic                              out_wait;
  logic                              mid_symbol;
  logic                              last_held;
  logic [rrc_si_pkg::SAMPLE_W:0]     out_word;

  assign in_xfer    = symbol_valid_i && !symbol_stall_o;
  assign out_wait   = sample_valid_o && sample_stall_i;
  assign mid_symbol = sample_valid_o && !last_of_symbol_o;
  assign last_held  = sample_valid_o && last_of_symbol_o;
  assign out_word   = {last_of_symbol_o, sample_o};

  // a stalled sample holds
  `ASSERT_ON(a_out_hold, clk_i, rst_ni, out_wait |=> sample_valid_o && $stable(out_word))

  // a symbol transfer makes the block busy
  `ASSERT_ON(a_busy_after_accept, clk_i, rst_ni, in_xfer |=> symbol_stall_o)

  // no new symbol while earlier samples of the current one are pending
  `ASSERT_NEVER(a_no_accept_mid_symbol, clk_i, rst_ni, mid_symbol && !symbol_stall_o)

  // the block frees up only with the last sample of a symbol in the output register
  `ASSERT_ON(a_free_on_last, clk_i, rst_ni, $fell(symbol_stall_o) |-> last_held)

endmodule

bind rrc_symbol_interpolator rrc_si_checker u_rrc_si_checker (.*);

// File: sim/rrc_symbol_interpolator_test.sv
// Self-checking testbench for the RRC symbol interpolator: predicted samples vs. DUT output.
`timescale 1ns / 1ps

module rrc_symbol_interpolator_test;
  import rrc_si_pkg::*;

  localparam int TAPS          = 81;
  localparam int UPSAMPLE_RATE = 10;
  localparam int HIST_LEN      = (TAPS - 1) / UPSAMPLE_RATE + 1;
  localparam int HALF_MID      = 40;
  localparam longint SAMPLE_GAIN = 362673;
  localparam longint FULL_SCALE  = 64'sd8388608;
  localparam int SAMPLE_TOP    = 4095;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_CYCLES   = 2000;
  localparam int SETTLE_CYCLES = 150;
  localparam int QUIET_LIMIT   = 20000;
  localparam int RANDOM_ITEMS  = 82;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Half of the symmetric Q1.15 response, through the center tap
  localparam int RRC_HALF_TAPS [0:HALF_MID] = '{
    -105, -96, -64, -12, 51, 111, 156, 174, 158, 108,
    31, -57, -139, -193, -202, -155, -56, 83, 236, 368,
    440, 417, 277, 14, -352, -777, -1196, -1524, -1670, -1551,
    -1100, -279, 908, 2414, 4151, 5996, 7801, 9412, 10684, 11498,
    11779
  };

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } dac_word_t;

  class rrc_sample_board;
    int        history [HIST_LEN];
    bit        invert;
    int        mid;
    dac_word_t waiting [$];
    int        failures;

    function new();
      foreach (history[m]) history[m] = 0;
      invert   = 1'b0;
      mid      = 2048;
      failures = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function int tap_at(int idx);
      int k;
      k = idx;
      if (k < 0 || k >= TAPS) return 0;
      if (k > HALF_MID) k = (TAPS - 1) - k;
      return RRC_HALF_TAPS[k];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_INVERT_PHASE: invert = data[0];
        CFG_MID_LEVEL:    mid = int'(data);
        default: ;
      endcase
    endfunction

    // Shift the symbol in and queue the ten samples it produces
    function void note_symbol(logic signed [SYM_W-1:0] raw);
      int        s;
      int        acc;
      int        idx;
      int        m;
      int        j;
      longint    total;
      dac_word_t w;
      s = int'(raw);
      if (!invert) begin
        s = -s;
        if (s > 3) s = 3;
      end
      for (m = HIST_LEN - 1; m > 0; m--) history[m] = history[m-1];
      history[0] = s;
      for (j = 0; j < UPSAMPLE_RATE; j++) begin
        acc = 0;
        for (m = 0; m < HIST_LEN; m++) begin
          idx = (TAPS - 1) - j - UPSAMPLE_RATE * m;
          if (idx >= 0) acc += history[m] * tap_at(idx);
        end
        total = longint'(acc) * SAMPLE_GAIN + longint'(mid) * FULL_SCALE;
        if (total < 0) begin
          w.sample = '0;
        end else if (total / FULL_SCALE > SAMPLE_TOP) begin
          w.sample = SAMPLE_W'(SAMPLE_TOP);
        end else begin
          w.sample = SAMPLE_W'(total / FULL_SCALE);
        end
        w.last = (j == UPSAMPLE_RATE - 1);
        waiting.push_back(w);
      end
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] sample, logic last);
      dac_word_t w;
      if (waiting.size() == 0) begin
        flag($sformatf("unexpected sample %0d last %0d", sample, last));
        return;
      end
      w = waiting.pop_front();
      if (sample !== w.sample || last !== w.last) begin
        flag($sformatf("sample mismatch: expected %0d last %0d, got %0d last %0d",
                       w.sample, w.last, sample, last));
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        symbol_valid_i;
  logic                        symbol_stall_o;
  logic signed [SYM_W-1:0]     symbol_i;
  logic                        sample_valid_o;
  logic                        sample_stall_i;
  logic [SAMPLE_W-1:0]         sample_o;
  logic                        last_of_symbol_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [CFG_DATA_W-1:0]       cfg_data_i;

  rrc_sample_board board;
  int              quiet_cycles;
  bit              hold_go;
  bit              hold_done;

  rrc_symbol_interpolator #(
    .TAP_COUNT(TAPS),
    .UPSAMPLE (UPSAMPLE_RATE)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .symbol_valid_i  (symbol_valid_i),
    .symbol_stall_o  (symbol_stall_o),
    .symbol_i        (symbol_i),
    .sample_valid_o  (sample_valid_o),
    .sample_stall_i  (sample_stall_i),
    .sample_o        (sample_o),
    .last_of_symbol_o(last_of_symbol_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [SYM_W-1:0] sym(int v);
    return SYM_W'(v);
  endfunction

  // Mostly the four data levels, some flushes, the odd out-of-range code
  function automatic logic signed [SYM_W-1:0] random_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return sym(2 * $urandom_range(0, 3) - 3);
    if (r < 90) return sym(0);
    if (r < 95) return sym(-4);
    return ($urandom_range(0, 1) != 0) ? sym(2) : sym(-2);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 130);
    return $urandom_range(131, 400);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] invert_word,
                                input logic [CFG_DATA_W-1:0] mid_word);
    write_reg(CFG_INVERT_PHASE, invert_word);
    write_reg(CFG_MID_LEVEL, mid_word);
    // Poke an unmapped index; the write must be dropped
    if ($urandom_range(0, 1) != 0) write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
    else write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
  endtask

  // Offer items in bursts; items up to index gapless go back to back
  task automatic send_items(input logic signed [SYM_W-1:0] items [$], input int gapless);
    int burst_left;
    burst_left = $urandom_range(1, 12);
    foreach (items[i]) begin
      symbol_valid_i <= 1'b1;
      symbol_i       <= items[i];
      do @(posedge clk_i); while (symbol_stall_o);
      burst_left--;
      if (burst_left <= 0 && i >= gapless && i != items.size() - 1) begin
        symbol_valid_i <= 1'b0;
        symbol_i       <= SYM_W'($urandom);
        repeat (pick_gap()) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
    end
    symbol_valid_i <= 1'b0;
  endtask

  task automatic drain();
    // let the monitor record the last symbol transfer first
    @(posedge clk_i);
    while (board.waiting.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(input int count, input int gapless);
    logic signed [SYM_W-1:0] items [$];
    int n;
    n = 0;
    while (n < count) begin
      // Now and then a full flush run to return the history to zero
      if ($urandom_range(0, 39) == 0) begin
        repeat (HIST_LEN) items.push_back(sym(0));
        n += HIST_LEN;
      end else begin
        items.push_back(random_symbol());
        n++;
      end
    end
    send_items(items, gapless);
    drain();
  endtask

  // Receiver: stall patterns that change every span, plus one long hold-off
  initial begin : sample_sink
    int mode;
    int span;
    int k;
    sample_stall_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_go && !hold_done) begin
        repeat (HOLD_CYCLES) begin
          sample_stall_i <= 1'b1;
          @(posedge clk_i);
        end
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 300);
        for (k = 0; k < span; k++) begin
          case (mode)
            0: sample_stall_i <= 1'b0;
            1: sample_stall_i <= ($urandom_range(0, 7) == 0);
            2: sample_stall_i <= ($urandom_range(0, 3) != 0);
            default: sample_stall_i <= ((k % 7) < 3);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : transfer_monitor
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        board.write_reg(cfg_index_i, cfg_data_i);
        moved = 1'b1;
      end
      if (symbol_valid_i && !symbol_stall_o) begin
        board.note_symbol(symbol_i);
        moved = 1'b1;
      end
      if (sample_valid_o && !sample_stall_i) begin
        board.check_sample(sample_o, last_of_symbol_o);
        moved = 1'b1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("rrc_symbol_interpolator regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic signed [SYM_W-1:0] items [$];
    board          = new();
    quiet_cycles   = 0;
    hold_go        = 1'b0;
    hold_done      = 1'b0;
    rst_ni         <= 1'b0;
    symbol_valid_i <= 1'b0;
    symbol_i       <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CFG_INVERT_PHASE;
    cfg_data_i     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: every level, the odd codes, -4 saturating to +3 when negated
    items = '{sym(3), sym(-3), sym(-4), sym(1), sym(-1), sym(2), sym(-2), sym(0)};
    send_items(items, 0);
    drain();

    // Pass-through, top offset: clip high; -4 enters as is
    apply_settings(12'hFFF, 12'd4095);
    items = '{sym(-4), sym(3), sym(3), sym(3), sym(3), sym(-3), sym(0)};
    send_items(items, 0);
    drain();

    // Only bit 0 of the invert word counts; zero offset clips low
    apply_settings(12'hFFE, 12'd0);
    items = '{sym(3), sym(3), sym(3), sym(-3), sym(-3), sym(1)};
    send_items(items, 0);
    drain();

    // Long receiver hold-off while the sender keeps offering
    apply_settings(12'd1, 12'd2048);
    hold_go = 1'b1;
    random_phase(RANDOM_ITEMS, 40);
    apply_settings(12'd0, 12'd0);
    random_phase(RANDOM_ITEMS, 0);
    apply_settings(12'd1, 12'd4095);
    random_phase(RANDOM_ITEMS, 0);
    apply_settings(12'd0, CFG_DATA_W'($urandom_range(0, 4095)));
    random_phase(RANDOM_ITEMS, 0);
    apply_settings(12'd1, CFG_DATA_W'($urandom_range(0, 4095)));
    random_phase(RANDOM_ITEMS, 0);

    if (board.failures == 0 && board.waiting.size() == 0) begin
      $display("rrc_symbol_interpolator regression: pass");
    end else begin
      $display("rrc_symbol_interpolator regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rrc_si_pkg.sv
hw/rtl/rrc_si_ctrl.sv
hw/rtl/rrc_si_mac.sv
hw/rtl/rrc_symbol_interpolator.sv
hw/rtl/rrc_si_checker.sv
sim/rrc_symbol_interpolator_test.sv
